// ----- hw/rtl/mbr_enc_pkg.sv -----
// types and constants shared by the mbr entry address encoder
// no dependencies
`default_nettype none

package mbr_enc_pkg;

    localparam int SECTOR_W    = 32;
    localparam int HPC_W       = 8;
    localparam int SPT_W       = 6;
    localparam int DISK_W      = 23;
    localparam int HALF_W      = DISK_W - 1;
    localparam int CHS_W       = 24;
    localparam int CYL_W       = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 23;
    // quotient bits resolved per divider stage
    localparam int STEP_BITS   = 4;

    localparam logic [HPC_W-1:0]  RESET_HEADS = 8'd255;
    localparam logic [SPT_W-1:0]  RESET_SPT   = 6'd63;
    localparam logic [DISK_W-1:0] RESET_DISK  = 23'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEADS = 2'd0,
        CFG_SPT   = 2'd1,
        CFG_DISK  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] start_sector;
        logic [SECTOR_W-1:0] length_sectors;
        logic [SECTOR_W-1:0] current_boot_start;
    } item_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] placed_start;
        logic [CHS_W-1:0]    start_chs;
        logic [CHS_W-1:0]    end_chs;
        logic [SECTOR_W-1:0] entry_length;
    } result_t;

    // one classified beat waiting between front and back
    typedef struct packed {
        logic [SECTOR_W-1:0] placed;
        logic [SECTOR_W-1:0] last;
        logic [SECTOR_W-1:0] length;
    } entry_t;

    // head in bits 7:0, sector and cylinder 9:8 in 15:8, cylinder 7:0 in 23:16
    function automatic logic [CHS_W-1:0] pack_chs(
        input logic [CYL_W-1:0] cyl,
        input logic [HPC_W-1:0] head,
        input logic [SPT_W-1:0] sec
    );
        pack_chs = {cyl[7:0], cyl[9:8], sec, head};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mbr_enc_front.sv -----
// front end: takes item beats, applies the pivot shift, registers placed start
// depends on mbr_enc_pkg
`default_nettype none

module mbr_enc_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire mbr_enc_pkg::item_t             item,
    input  wire logic [mbr_enc_pkg::DISK_W-1:0] disk_sectors,
    output logic                                wr_valid,
    input  wire logic                           wr_ready,
    output mbr_enc_pkg::entry_t                 wr_entry
);
    import mbr_enc_pkg::*;

    logic                front_valid_reg;
    logic                front_valid_next;
    logic [SECTOR_W-1:0] placed_reg;
    logic [SECTOR_W-1:0] length_reg;
    logic [SECTOR_W-1:0] half;
    logic [SECTOR_W-1:0] placed_next;
    logic                take;

    assign item_ready = !front_valid_reg || wr_ready;
    assign take       = item_valid && item_ready;

    assign half = {{(SECTOR_W - HALF_W){1'b0}}, disk_sectors[DISK_W-1:1]};

    always_comb
    begin
        if (item.current_boot_start < half)
        begin
            placed_next = item.start_sector + half;
        end
        else
        begin
            placed_next = item.start_sector;
        end
    end

    always_comb
    begin
        priority if (take)
        begin
            front_valid_next = 1'b1;
        end
        else if (wr_ready)
        begin
            front_valid_next = 1'b0;
        end
        else
        begin
            front_valid_next = front_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            placed_reg <= placed_next;
            length_reg <= item.length_sectors;
        end
    end

    // last sector wraps modulo 2^32, also for zero length
    assign wr_valid        = front_valid_reg;
    assign wr_entry.placed = placed_reg;
    assign wr_entry.last   = placed_reg + length_reg - SECTOR_W'(1);
    assign wr_entry.length = length_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mbr_enc_queue.sv -----
// short fifo between the front end and the chs back end
// depends on mbr_enc_pkg
`default_nettype none

module mbr_enc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_valid,
    output logic                     wr_ready,
    input  wire mbr_enc_pkg::entry_t wr_entry,
    input  wire logic                pop,
    output logic                     head_valid,
    output mbr_enc_pkg::entry_t      head_entry
);
    import mbr_enc_pkg::*;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    entry_t             store [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               push;
    logic               do_pop;

    assign wr_ready   = (count_reg != COUNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = store[rd_ptr_reg];
    assign push       = wr_valid && wr_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mbr_enc_divider.sv -----
// pipelined restoring divider, STEP_BITS quotient bits per stage, sideband carried along
// depends on mbr_enc_pkg
`default_nettype none

module mbr_enc_divider #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 6,
    parameter int SIDE_W     = 1
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    input  wire logic [SIDE_W-1:0]     side_in,
    output logic [DIVIDEND_W-1:0]      quotient,
    output logic [DIVISOR_W-1:0]       remainder,
    output logic [SIDE_W-1:0]          side_out
);
    import mbr_enc_pkg::*;

    localparam int STAGES = DIVIDEND_W / STEP_BITS;

    logic [DIVISOR_W-1:0]  rem_reg  [STAGES];
    logic [DIVIDEND_W-1:0] dq_reg   [STAGES];
    logic [SIDE_W-1:0]     side_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [DIVISOR_W-1:0]  rem_in;
        logic [DIVIDEND_W-1:0] dq_in;
        logic [SIDE_W-1:0]     side_stage;
        logic [DIVISOR_W-1:0]  rem_next;
        logic [DIVIDEND_W-1:0] dq_next;

        if (s == 0)
        begin : g_first
            assign rem_in     = '0;
            assign dq_in      = dividend;
            assign side_stage = side_in;
        end
        else
        begin : g_rest
            assign rem_in     = rem_reg[s-1];
            assign dq_in      = dq_reg[s-1];
            assign side_stage = side_reg[s-1];
        end

        // dividend bits shift out at the top, quotient bits shift in at the bottom
        always_comb
        begin : p_step
            logic [DIVISOR_W:0] ext;
            rem_next = rem_in;
            dq_next  = dq_in;
            for (int k = 0; k < STEP_BITS; k++)
            begin
                ext     = {rem_next, dq_next[DIVIDEND_W-1]};
                dq_next = {dq_next[DIVIDEND_W-2:0], 1'b0};
                if (ext >= {1'b0, divisor})
                begin
                    ext        = ext - {1'b0, divisor};
                    dq_next[0] = 1'b1;
                end
                rem_next = ext[DIVISOR_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                dq_reg[s]   <= dq_next;
                side_reg[s] <= side_stage;
            end
        end
    end

    assign quotient  = dq_reg[STAGES-1];
    assign remainder = rem_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

`default_nettype wire

// ----- hw/rtl/mbr_enc_back.sv -----
// back end: lba to packed chs for first and last sector, output register
// depends on mbr_enc_pkg, mbr_enc_divider
`default_nettype none

module mbr_enc_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          head_valid,
    input  wire mbr_enc_pkg::entry_t           head_entry,
    output logic                               pop,
    input  wire logic [mbr_enc_pkg::SPT_W-1:0] spt,
    input  wire logic [mbr_enc_pkg::HPC_W-1:0] hpc,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output mbr_enc_pkg::result_t               result
);
    import mbr_enc_pkg::*;

    localparam int DIV_STAGES = SECTOR_W / STEP_BITS;
    localparam int PIPE_LEN   = 2 * DIV_STAGES;
    localparam int SIDE1_W    = SECTOR_W;
    localparam int SIDE2F_W   = 2 * SECTOR_W + SPT_W;

    logic                advance;
    logic [PIPE_LEN-1:0] valid_reg;
    logic                out_valid_reg;
    result_t             result_reg;
    logic [SPT_W-1:0]    spt_eff;
    logic [HPC_W-1:0]    hpc_eff;

    // first divide: lba by sectors per track
    logic [SECTOR_W-1:0] q1_first;
    logic [SECTOR_W-1:0] q1_last;
    logic [SPT_W-1:0]    r1_first;
    logic [SPT_W-1:0]    r1_last;
    logic [SIDE1_W-1:0]  s1_first;
    logic [SIDE1_W-1:0]  s1_last;

    // second divide: track number by heads
    logic [SECTOR_W-1:0] q2_first;
    logic [SECTOR_W-1:0] q2_last;
    logic [HPC_W-1:0]    r2_first;
    logic [HPC_W-1:0]    r2_last;
    logic [SIDE2F_W-1:0] s2_first;
    logic [SPT_W-1:0]    s2_last;

    logic [SECTOR_W-1:0] fin_length;
    logic [SECTOR_W-1:0] fin_placed;
    logic [SPT_W-1:0]    fin_r1_first;

    // zero geometry acts as one
    assign spt_eff = (spt == '0) ? SPT_W'(1) : spt;
    assign hpc_eff = (hpc == '0) ? HPC_W'(1) : hpc;

    // whole pipe moves together unless the output beat is stuck
    assign advance = !out_valid_reg || result_ready;
    assign pop     = advance && head_valid;

    mbr_enc_divider #(
        .DIVIDEND_W (SECTOR_W),
        .DIVISOR_W  (SPT_W),
        .SIDE_W     (SIDE1_W)
    ) u_div1_first (
        .clk       (clk),
        .en        (advance),
        .dividend  (head_entry.placed),
        .divisor   (spt_eff),
        .side_in   (head_entry.length),
        .quotient  (q1_first),
        .remainder (r1_first),
        .side_out  (s1_first)
    );

    mbr_enc_divider #(
        .DIVIDEND_W (SECTOR_W),
        .DIVISOR_W  (SPT_W),
        .SIDE_W     (SIDE1_W)
    ) u_div1_last (
        .clk       (clk),
        .en        (advance),
        .dividend  (head_entry.last),
        .divisor   (spt_eff),
        .side_in   (head_entry.placed),
        .quotient  (q1_last),
        .remainder (r1_last),
        .side_out  (s1_last)
    );

    mbr_enc_divider #(
        .DIVIDEND_W (SECTOR_W),
        .DIVISOR_W  (HPC_W),
        .SIDE_W     (SIDE2F_W)
    ) u_div2_first (
        .clk       (clk),
        .en        (advance),
        .dividend  (q1_first),
        .divisor   (hpc_eff),
        .side_in   ({s1_first, s1_last, r1_first}),
        .quotient  (q2_first),
        .remainder (r2_first),
        .side_out  (s2_first)
    );

    mbr_enc_divider #(
        .DIVIDEND_W (SECTOR_W),
        .DIVISOR_W  (HPC_W),
        .SIDE_W     (SPT_W)
    ) u_div2_last (
        .clk       (clk),
        .en        (advance),
        .dividend  (q1_last),
        .divisor   (hpc_eff),
        .side_in   (r1_last),
        .quotient  (q2_last),
        .remainder (r2_last),
        .side_out  (s2_last)
    );

    assign {fin_length, fin_placed, fin_r1_first} = s2_first;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= {valid_reg[PIPE_LEN-2:0], head_valid};
            out_valid_reg <= valid_reg[PIPE_LEN-1];
        end
    end

    // sector is the remainder plus one, cylinder keeps its low 10 bits
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.placed_start <= fin_placed;
            result_reg.start_chs    <= pack_chs(q2_first[CYL_W-1:0], r2_first,
                                                fin_r1_first + SPT_W'(1));
            result_reg.end_chs      <= pack_chs(q2_last[CYL_W-1:0], r2_last,
                                                s2_last + SPT_W'(1));
            result_reg.entry_length <= fin_length;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mbr_entry_address_encoder_core.sv -----
// mbr entry address encoder: pivot placement and lba to packed chs
// path from item beat to result beat: front register, queue,
// 16 divider stages, output register; one item per cycle sustained unless result_ready stalls
// the two chained dividers resolve 4 quotient bits per stage
// async active-low reset empties front, queue and pipe and loads geometry defaults
// depends on mbr_enc_pkg, mbr_enc_front, mbr_enc_queue, mbr_enc_back
`default_nettype none

module mbr_entry_address_encoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_ready,
    input  wire mbr_enc_pkg::item_t                  item,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output mbr_enc_pkg::result_t                     result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mbr_enc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mbr_enc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mbr_enc_pkg::*;

    logic [HPC_W-1:0]  heads_reg;
    logic [SPT_W-1:0]  spt_reg;
    logic [DISK_W-1:0] disk_reg;

    logic   wr_valid;
    logic   wr_ready;
    entry_t wr_entry;
    logic   pop;
    logic   head_valid;
    entry_t head_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heads_reg <= RESET_HEADS;
            spt_reg   <= RESET_SPT;
            disk_reg  <= RESET_DISK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_HEADS: heads_reg <= cfg_data[HPC_W-1:0];
                CFG_SPT:   spt_reg   <= cfg_data[SPT_W-1:0];
                CFG_DISK:  disk_reg  <= cfg_data[DISK_W-1:0];
                default:   ;
            endcase
        end
    end

    mbr_enc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .disk_sectors (disk_reg),
        .wr_valid     (wr_valid),
        .wr_ready     (wr_ready),
        .wr_entry     (wr_entry)
    );

    mbr_enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_valid   (wr_valid),
        .wr_ready   (wr_ready),
        .wr_entry   (wr_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    mbr_enc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .spt          (spt_reg),
        .hpc          (heads_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/mbr_enc_checker.sv -----
// port-level checks for the mbr entry address encoder, bound to the top level
// depends on mbr_enc_pkg
`default_nettype none

module mbr_enc_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 item_ready,
    input wire logic                 result_valid,
    input wire logic                 result_ready,
    input wire mbr_enc_pkg::result_t result
);
    import mbr_enc_pkg::*;

    // a stalled result beat stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat dropped or changed while stalled");

    // sector numbers are one-based, never zero
    a_sector_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.start_chs[13:8] != '0) && (result.end_chs[13:8] != '0))
        else $error("chs sector field is zero");

    // nothing comes out while reset is held
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid during reset");

    // empty after reset, so the first item can be taken at once
    a_ready_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> item_ready)
        else $error("item not accepted right after reset");

endmodule

bind mbr_entry_address_encoder_core mbr_enc_checker u_checker (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// self-checking bench for mbr_entry_address_encoder_core: directed and random partition
// entries under changing disk geometry, checked against a local pivot and chs encoder
// depends on mbr_enc_pkg and mbr_entry_address_encoder_core

module testbench;

    import mbr_enc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ENTRIES  = 105;
    localparam int MAX_REPORTS    = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   item_valid = 1'b0;
    logic                   item_ready;
    item_t                  item = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // geometry as the block should hold it
    logic [HPC_W-1:0]  geo_heads;
    logic [SPT_W-1:0]  geo_spt;
    logic [DISK_W-1:0] geo_disk;

    item_t   pending_entries[$];
    result_t expected_entries[$];

    int unsigned send_idle_pct = 12;
    int unsigned stall_pct     = 70;
    int unsigned mismatches    = 0;
    int unsigned entries_seen  = 0;
    int unsigned reg_writes    = 0;
    int unsigned geometries    = 1;
    int unsigned quiet_cycles  = 0;

    mbr_entry_address_encoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [CHS_W-1:0] chs_of_sector(input logic [SECTOR_W-1:0] lba);
        logic [63:0] hpc;
        logic [63:0] spt;
        logic [63:0] cyl;
        logic [63:0] head;
        logic [63:0] sec;
        // a zero in either geometry register counts as one
        hpc  = (geo_heads == '0) ? 64'd1 : 64'(geo_heads);
        spt  = (geo_spt == '0) ? 64'd1 : 64'(geo_spt);
        cyl  = 64'(lba) / (spt * hpc);
        head = (64'(lba) / spt) % hpc;
        sec  = (64'(lba) % spt) + 64'd1;
        return {cyl[7:0], cyl[9:8], sec[5:0], head[7:0]};
    endfunction

    function automatic result_t encode_entry(input item_t it);
        result_t r;
        logic [SECTOR_W-1:0] half;
        logic [SECTOR_W-1:0] placed;
        logic [SECTOR_W-1:0] last;
        half   = SECTOR_W'(geo_disk >> 1);
        placed = it.start_sector;
        if (it.current_boot_start < half)
            placed = it.start_sector + half;
        last = placed + it.length_sectors - 32'd1;
        r.placed_start = placed;
        r.start_chs    = chs_of_sector(placed);
        r.end_chs      = chs_of_sector(last);
        r.entry_length = it.length_sectors;
        return r;
    endfunction

    function automatic item_t make_entry(input logic [31:0] s, input logic [31:0] l,
                                         input logic [31:0] b);
        item_t it;
        it.start_sector       = s;
        it.length_sectors     = l;
        it.current_boot_start = b;
        return it;
    endfunction

    function automatic item_t random_entry(input logic [31:0] half);
        logic [31:0] s;
        logic [31:0] l;
        logic [31:0] b;
        case ($urandom_range(7))
            0, 1, 2: s = $urandom;
            3, 4:    s = $urandom_range(20000000);
            5:       s = 32'hFFFF_FFFF - $urandom_range(4096);
            6:       s = $urandom_range(64);
            default: s = $urandom_range(32'h00FF_FFFF);
        endcase
        case ($urandom_range(7))
            0:       l = 32'd0;
            1:       l = 32'hFFFF_FFFF;
            2, 3:    l = $urandom_range(5000000, 1);
            default: l = $urandom;
        endcase
        case ($urandom_range(7))
            0, 1:    b = (half == 0) ? 32'd0 : $urandom_range(half - 1);
            2:       b = half;
            3:       b = half - 32'd1;
            4:       b = half + $urandom_range(1000);
            default: b = $urandom;
        endcase
        return make_entry(s, l, b);
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endtask

    // driver: next entry goes out once the current beat is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else if (!item_valid || item_ready)
        begin
            if (pending_entries.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item       <= pending_entries.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // monitor: tracks register writes, predicts accepted entries, checks results
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            geo_heads    <= RESET_HEADS;
            geo_spt      <= RESET_SPT;
            geo_disk     <= RESET_DISK;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                case (cfg_index)
                    CFG_HEADS: geo_heads <= cfg_data[HPC_W-1:0];
                    CFG_SPT:   geo_spt   <= cfg_data[SPT_W-1:0];
                    CFG_DISK:  geo_disk  <= cfg_data[DISK_W-1:0];
                    default:   ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                entries_seen++;
                expected_entries.push_back(encode_entry(item));
            end
            if (result_valid && result_ready)
            begin
                if (expected_entries.size() == 0)
                    note_mismatch("unexpected result beat", '0, result.placed_start);
                else
                begin
                    want = expected_entries.pop_front();
                    if (result.placed_start !== want.placed_start)
                        note_mismatch("placed_start", want.placed_start, result.placed_start);
                    if (result.start_chs !== want.start_chs)
                        note_mismatch("start_chs", 32'(want.start_chs), 32'(result.start_chs));
                    if (result.end_chs !== want.end_chs)
                        note_mismatch("end_chs", 32'(want.end_chs), 32'(result.end_chs));
                    if (result.entry_length !== want.entry_length)
                        note_mismatch("entry_length", want.entry_length, result.entry_length);
                end
            end
            result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // holds valid high across back-to-back writes; caller lowers it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_geometry(input logic [CFG_DATA_W-1:0] hpc_word,
                                    input logic [CFG_DATA_W-1:0] spt_word,
                                    input logic [CFG_DATA_W-1:0] disk_word,
                                    input bit poke_unused);
        write_reg(CFG_HEADS, hpc_word);
        write_reg(CFG_SPT, spt_word);
        write_reg(CFG_DISK, disk_word);
        // unmapped index must leave the geometry alone
        if (poke_unused)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        geometries++;
    endtask

    task automatic wait_drained();
        while (pending_entries.size() != 0 || item_valid || expected_entries.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [HPC_W-1:0]      hpc;
        logic [SPT_W-1:0]      spt;
        logic [DISK_W-1:0]     disk;
        logic [CFG_DATA_W-1:0] noise;
        logic [31:0]           half;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry, no pivot possible
        pending_entries.push_back(make_entry(32'd0, 32'd0, 32'd0));
        pending_entries.push_back(make_entry(32'd0, 32'd1, 32'd0));
        pending_entries.push_back(make_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_entries.push_back(make_entry(32'd16450559, 32'd1, 32'd0));
        pending_entries.push_back(make_entry(32'd16450560, 32'd16450560, 32'd0));
        pending_entries.push_back(make_entry(32'd1234567, 32'd0, 32'd5));
        wait_drained();

        // largest disk: pivot boundary and address wrap
        program_geometry(23'd255, 23'd63, 23'd8388607, 1'b1);
        pending_entries.push_back(make_entry(32'd100, 32'd50, 32'd0));
        pending_entries.push_back(make_entry(32'd100, 32'd50, 32'd4194302));
        pending_entries.push_back(make_entry(32'd100, 32'd50, 32'd4194303));
        pending_entries.push_back(make_entry(32'hFFFF_FFFF, 32'd2, 32'd0));
        pending_entries.push_back(make_entry(32'hFFC0_0002, 32'd1, 32'd0));
        pending_entries.push_back(make_entry(32'd0, 32'd0, 32'd4194303));
        pending_entries.push_back(make_entry(32'd0, 32'hFFFF_FFFF, 32'd0));
        pending_entries.push_back(make_entry(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555));
        pending_entries.push_back(make_entry(32'h5555_5555, 32'hAAAA_AAAA, 32'd0));
        wait_drained();

        // zero geometry behaves as one head, one sector
        program_geometry(23'h7FFF00, 23'h7FFFC0, 23'd2, 1'b1);
        pending_entries.push_back(make_entry(32'd5, 32'd3, 32'd0));
        pending_entries.push_back(make_entry(32'd7, 32'd1, 32'd1));
        pending_entries.push_back(make_entry(32'hFFFF_FFFF, 32'd0, 32'd0));
        wait_drained();

        // one head, one sector: cylinder equals lba and gets truncated
        program_geometry(23'd1, 23'd1, 23'd1, 1'b0);
        pending_entries.push_back(make_entry(32'd1023, 32'd2, 32'd0));
        pending_entries.push_back(make_entry(32'd1024, 32'd1, 32'd0));
        pending_entries.push_back(make_entry(32'hDEAD_BEEF, 32'h1234_5678, 32'd0));
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p / 4)
                0:       begin send_idle_pct = 12; stall_pct = 70; end
                1:       begin send_idle_pct = 70; stall_pct = 12; end
                default: begin send_idle_pct = 0;  stall_pct = 0;  end
            endcase
            case (p)
                0:       begin hpc = 8'd255; spt = 6'd63; disk = 23'd8388607; end
                1:       begin hpc = 8'd1;   spt = 6'd1;  disk = 23'd0;       end
                2:       begin hpc = 8'd2;   spt = 6'd63; disk = 23'd3;       end
                default:
                begin
                    hpc  = ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
                    spt  = ($urandom_range(15) == 0) ? 6'd0 : 6'($urandom_range(63, 1));
                    disk = ($urandom_range(3) == 0)
                           ? ($urandom_range(1) ? 23'd8388607 : 23'($urandom_range(3)))
                           : 23'($urandom_range(8388607));
                end
            endcase
            noise = CFG_DATA_W'($urandom);
            program_geometry((noise & 23'h7FFF00) | hpc, (noise & 23'h7FFFC0) | spt, disk,
                             (p % 3) == 1);
            half = 32'(disk >> 1);
            for (int n = 0; n < PHASE_ENTRIES; n++)
                pending_entries.push_back(random_entry(half));
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_entries.size() != 0)
            note_mismatch("results never delivered", '0, expected_entries.size());

        $display("covered %0d entries across %0d geometry settings, %0d register writes",
                 entries_seen, geometries, reg_writes);
        $display("mismatching fields: %0d", mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mbr_enc_pkg.sv
hw/rtl/mbr_enc_front.sv
hw/rtl/mbr_enc_queue.sv
hw/rtl/mbr_enc_divider.sv
hw/rtl/mbr_enc_back.sv
hw/rtl/mbr_entry_address_encoder_core.sv
hw/rtl/mbr_enc_checker.sv
tb/sv/testbench.sv
